// ===== hw/rtl/r5a3ds_pkg.sv =====
// Shared types and constants for the RGB5A3 2x2 premultiplied downsample unit.
// Holds the channel payload structs, the per-stage structs and the texel expansion tables.
// No dependencies.
package r5a3ds_pkg;

   localparam int NUM_LANES       = 4;
   localparam int TEXEL_W         = 16;
   localparam int CH_W            = 8;
   localparam int PROD_W          = 2 * CH_W;
   localparam int SUM_W           = PROD_W + 2;
   localparam int ASUM_W          = CH_W + 2;
   localparam int DIV_STEPS       = CH_W;
   localparam int COV_W           = 6;
   localparam int COV_X_W         = 16;
   localparam int COV_SCALE_SHIFT = 5;
   localparam int COV_EST_SHIFT   = 18;
   localparam int OPAQUE_BIT      = 15;

   localparam logic [CH_W-1:0]    ALPHA_OPAQUE = 8'd255;
   localparam logic [COV_X_W-1:0] COV_ROUND    = 16'd510;
   localparam logic [COV_X_W-1:0] COV_DIVISOR  = 16'd1020;

   // c * 255 / 31, truncated
   localparam logic [CH_W-1:0] EXPAND5_TABLE [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   // (a * 255 + 3) / 7
   localparam logic [CH_W-1:0] EXPAND3_TABLE [8] = '{
      8'd0, 8'd36, 8'd73, 8'd109, 8'd146, 8'd182, 8'd219, 8'd255
   };

   typedef struct packed {
      logic [TEXEL_W-1:0] texel_top_left;
      logic [TEXEL_W-1:0] texel_top_right;
      logic [TEXEL_W-1:0] texel_bottom_left;
      logic [TEXEL_W-1:0] texel_bottom_right;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]      pixel_rgb565;
      logic [COV_W-1:0] coverage;
   } rsp_payload_type;

   typedef struct packed {
      logic expand_en;
      logic weight_en;
   } lane_ctl_type;

   typedef struct packed {
      logic [PROD_W-1:0] r_prod;
      logic [PROD_W-1:0] g_prod;
      logic [PROD_W-1:0] b_prod;
      logic [CH_W-1:0]   alpha;
   } lane_out_type;

   typedef struct packed {
      logic [SUM_W-1:0]  r_sum;
      logic [SUM_W-1:0]  g_sum;
      logic [SUM_W-1:0]  b_sum;
      logic [ASUM_W-1:0] a_sum;
   } sum_type;

   typedef struct packed {
      logic [SUM_W-1:0]   rem_r;
      logic [SUM_W-1:0]   rem_g;
      logic [SUM_W-1:0]   rem_b;
      logic [CH_W-1:0]    quo_r;
      logic [CH_W-1:0]    quo_g;
      logic [CH_W-1:0]    quo_b;
      logic [ASUM_W-1:0]  a_sum;
      logic [COV_X_W-1:0] cov_x;
      logic [COV_W-1:0]   cov_q;
   } div_stage_type;

endpackage

// ===== hw/rtl/r5a3ds_lane.sv =====
// One texel lane: expands an RGB5A3 texel to 8-bit RGBA, then weights the colour by alpha.
// Two register stages. Depends on r5a3ds_pkg.
module r5a3ds_lane (
   input  logic                       clock,
   input  r5a3ds_pkg::lane_ctl_type   ctl,
   input  logic [15:0]                texel,
   output r5a3ds_pkg::lane_out_type   lane_out
);
   import r5a3ds_pkg::*;

   logic [CH_W-1:0] r_in, g_in, b_in, a_in;
   logic [CH_W-1:0] r_ff, g_ff, b_ff, a_ff;
   lane_out_type    lane_in, lane_ff;

   always_comb begin
      if (texel[OPAQUE_BIT]) begin
         a_in = ALPHA_OPAQUE;
         r_in = EXPAND5_TABLE[texel[14:10]];
         g_in = EXPAND5_TABLE[texel[9:5]];
         b_in = EXPAND5_TABLE[texel[4:0]];
      end else begin
         a_in = EXPAND3_TABLE[texel[14:12]];
         // times 17 is the nibble repeated
         r_in = {texel[11:8], texel[11:8]};
         g_in = {texel[7:4], texel[7:4]};
         b_in = {texel[3:0], texel[3:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.expand_en) begin
         r_ff <= r_in;
         g_ff <= g_in;
         b_ff <= b_in;
         a_ff <= a_in;
      end
   end

   always_comb begin
      lane_in.r_prod = PROD_W'(r_ff) * PROD_W'(a_ff);
      lane_in.g_prod = PROD_W'(g_ff) * PROD_W'(a_ff);
      lane_in.b_prod = PROD_W'(b_ff) * PROD_W'(a_ff);
      lane_in.alpha  = a_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.weight_en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== hw/rtl/r5a3ds_merge.sv =====
// Merge stage: sums the weighted colours and alphas of all lanes into one register.
// Depends on r5a3ds_pkg.
module r5a3ds_merge (
   input  logic                                                clock,
   input  logic                                                merge_en,
   input  r5a3ds_pkg::lane_out_type [r5a3ds_pkg::NUM_LANES-1:0] lane_out,
   output r5a3ds_pkg::sum_type                                 sum
);
   import r5a3ds_pkg::*;

   sum_type sum_in, sum_ff;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         sum_in.r_sum = sum_in.r_sum + SUM_W'(lane_out[k].r_prod);
         sum_in.g_sum = sum_in.g_sum + SUM_W'(lane_out[k].g_prod);
         sum_in.b_sum = sum_in.b_sum + SUM_W'(lane_out[k].b_prod);
         sum_in.a_sum = sum_in.a_sum + ASUM_W'(lane_out[k].alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (merge_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== hw/rtl/r5a3ds_divide.sv =====
// Pipelined restoring divider: one quotient bit per stage for each colour channel,
// plus the coverage rounding carried alongside. Depends on r5a3ds_pkg.
module r5a3ds_divide (
   input  logic                                 clock,
   input  logic [r5a3ds_pkg::DIV_STEPS-1:0]     step_en,
   input  r5a3ds_pkg::sum_type                  sum,
   output r5a3ds_pkg::rsp_payload_type          result
);
   import r5a3ds_pkg::*;

   // coverage: estimate in one step, fix up by at most one in the next
   localparam int COV_EST_STEP = 1;
   localparam int COV_FIX_STEP = 2;

   div_stage_type head;
   div_stage_type step_ff [DIV_STEPS];
   div_stage_type last;

   always_comb begin
      head       = '0;
      head.rem_r = sum.r_sum;
      head.rem_g = sum.g_sum;
      head.rem_b = sum.b_sum;
      head.a_sum = sum.a_sum;
      head.cov_x = COV_X_W'({sum.a_sum, COV_SCALE_SHIFT'(0)}) + COV_ROUND;
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      localparam int BIT = DIV_STEPS - 1 - i;

      div_stage_type                  cur;
      div_stage_type                  nxt;
      logic [SUM_W-1:0]               dsr;
      logic [COV_X_W+CH_W-1:0]        est_prod;
      logic [COV_X_W-1:0]             cov_base;
      logic [COV_X_W-1:0]             cov_rem;

      if (i == 0) begin : g_first
         assign cur = head;
      end else begin : g_next
         assign cur = step_ff[i-1];
      end

      assign dsr      = SUM_W'(cur.a_sum) << BIT;
      // x * 257 >> 18 never overshoots x / 1020 and falls short by at most one
      assign est_prod = {cur.cov_x, CH_W'(0)} + (COV_X_W+CH_W)'(cur.cov_x);
      assign cov_base = COV_X_W'({cur.cov_q, 10'd0}) - COV_X_W'({cur.cov_q, 2'd0});
      assign cov_rem  = cur.cov_x - cov_base;

      always_comb begin
         nxt = cur;
         if (cur.rem_r >= dsr) begin
            nxt.rem_r      = cur.rem_r - dsr;
            nxt.quo_r[BIT] = 1'b1;
         end
         if (cur.rem_g >= dsr) begin
            nxt.rem_g      = cur.rem_g - dsr;
            nxt.quo_g[BIT] = 1'b1;
         end
         if (cur.rem_b >= dsr) begin
            nxt.rem_b      = cur.rem_b - dsr;
            nxt.quo_b[BIT] = 1'b1;
         end
         if (i == COV_EST_STEP) begin
            nxt.cov_q = est_prod[COV_EST_SHIFT +: COV_W];
         end
         if (i == COV_FIX_STEP && cov_rem >= COV_DIVISOR) begin
            nxt.cov_q = cur.cov_q + COV_W'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (step_en[i]) begin
            step_ff[i] <= nxt;
         end
      end
   end

   assign last = step_ff[DIV_STEPS-1];

   always_comb begin
      result.coverage = last.cov_q;
      // zero alpha sum: the divider saturates, force black
      if (last.a_sum == '0) begin
         result.pixel_rgb565 = '0;
      end else begin
         result.pixel_rgb565 = {last.quo_r[7:3], last.quo_g[7:2], last.quo_b[7:3]};
      end
   end

endmodule

// ===== hw/rtl/rgb5a3_premultiplied_2x2_downsample_unit.sv =====
// Throughput: one beat per cycle while the output is not stalled; a 12-stage pipeline
// (expand, weight, merge, 8 restoring divide steps, output register) with per-stage valid bits.
// A stage advances when it is empty or the stage after it advances.
// Reset clears the valid bits only; payload registers are not reset.
module rgb5a3_premultiplied_2x2_downsample_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  r5a3ds_pkg::req_payload_type     req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output r5a3ds_pkg::rsp_payload_type     rsp_payload
);
   import r5a3ds_pkg::*;

   localparam int ST_EXPAND  = 0;
   localparam int ST_WEIGHT  = 1;
   localparam int ST_MERGE   = 2;
   localparam int ST_DIV     = 3;
   localparam int ST_OUT     = ST_DIV + DIV_STEPS;
   localparam int NUM_STAGES = ST_OUT + 1;

   logic [NUM_STAGES-1:0]                valid_ff, valid_in, adv;
   logic [NUM_LANES-1:0][TEXEL_W-1:0]    texel;
   lane_ctl_type                         lane_ctl;
   lane_out_type [NUM_LANES-1:0]         lane_out;
   sum_type                              sum;
   rsp_payload_type                      div_result;
   rsp_payload_type                      rsp_payload_ff;

   always_comb begin
      adv[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign texel[0] = req_payload.texel_top_left;
   assign texel[1] = req_payload.texel_top_right;
   assign texel[2] = req_payload.texel_bottom_left;
   assign texel[3] = req_payload.texel_bottom_right;

   assign lane_ctl.expand_en = adv[ST_EXPAND];
   assign lane_ctl.weight_en = adv[ST_WEIGHT];

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      r5a3ds_lane u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .texel    (texel[k]),
         .lane_out (lane_out[k])
      );
   end

   r5a3ds_merge u_merge (
      .clock    (clock),
      .merge_en (adv[ST_MERGE]),
      .lane_out (lane_out),
      .sum      (sum)
   );

   r5a3ds_divide u_divide (
      .clock   (clock),
      .step_en (adv[ST_DIV +: DIV_STEPS]),
      .sum     (sum),
      .result  (div_result)
   );

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         rsp_payload_ff <= div_result;
      end
   end

   assign req_ready   = adv[ST_EXPAND];
   assign rsp_valid   = valid_ff[ST_OUT];
   assign rsp_payload = rsp_payload_ff;

   // coverage never exceeds fully opaque
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.coverage <= 6'd32)
      else $error("coverage above 32");

   // zero coverage only comes from a zero alpha sum, which must give black
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.coverage == '0 |-> rsp_payload.pixel_rgb565 == '0)
      else $error("transparent pixel not black");

   // the pipeline only backs up when the output beat is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with no output backpressure");

endmodule

// ===== sim/tb_rgb5a3_premultiplied_2x2_downsample_unit.sv =====
// Self-checking testbench for the RGB5A3 2x2 premultiplied downsample unit.
// Drives quads of texels over req_, checks RGB565 pixel and coverage on rsp_.
// Depends on r5a3ds_pkg and rgb5a3_premultiplied_2x2_downsample_unit.
module tb_rgb5a3_premultiplied_2x2_downsample_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import r5a3ds_pkg::*;

   localparam int RANDOM_QUADS = 1300;
   localparam int IDLE_PCT     = 12;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 30;
   localparam int PRINT_CAP    = 40;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type pending_quads[$];
   rsp_payload_type expected_pixels[$];

   int sent_count     = 0;
   int taken_count    = 0;
   int quiet_cycles   = 0;
   int mismatch_count = 0;
   logic calm;

   rgb5a3_premultiplied_2x2_downsample_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // long stretch with no idling on either side
   assign calm = (taken_count >= 400) && (taken_count < 700);

   function automatic rsp_payload_type filter_quad(req_payload_type quad);
      logic [TEXEL_W-1:0] texel [4];
      int unsigned r, g, b, a;
      int unsigned sum_r, sum_g, sum_b, sum_a;
      rsp_payload_type pix;
      texel[0] = quad.texel_top_left;
      texel[1] = quad.texel_top_right;
      texel[2] = quad.texel_bottom_left;
      texel[3] = quad.texel_bottom_right;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      sum_a = 0;
      for (int k = 0; k < 4; k++) begin
         if (texel[k][15]) begin
            a = 255;
            r = int'(texel[k][14:10]) * 255 / 31;
            g = int'(texel[k][9:5]) * 255 / 31;
            b = int'(texel[k][4:0]) * 255 / 31;
         end else begin
            a = (int'(texel[k][14:12]) * 255 + 3) / 7;
            r = int'(texel[k][11:8]) * 17;
            g = int'(texel[k][7:4]) * 17;
            b = int'(texel[k][3:0]) * 17;
         end
         sum_a += a;
         sum_r += r * a;
         sum_g += g * a;
         sum_b += b * a;
      end
      // all four transparent: color sums are zero, skip the divide
      if (sum_a != 0) begin
         sum_r /= sum_a;
         sum_g /= sum_a;
         sum_b /= sum_a;
      end
      pix.pixel_rgb565 = {sum_r[7:3], sum_g[7:2], sum_b[7:3]};
      pix.coverage     = 6'((sum_a * 32 + 510) / 1020);
      return pix;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic push_quad(input logic [15:0] tl, input logic [15:0] tr,
                            input logic [15:0] bl, input logic [15:0] br);
      req_payload_type quad;
      quad.texel_top_left     = tl;
      quad.texel_top_right    = tr;
      quad.texel_bottom_left  = bl;
      quad.texel_bottom_right = br;
      pending_quads.push_back(quad);
   endtask

   // driver: change inputs at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // advance once every driven beat has been taken
         if (taken_count == sent_count) begin
            if (pending_quads.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_payload <= pending_quads.pop_front();
               req_valid   <= 1'b1;
               sent_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected beat", 32'(rsp_payload), 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_payload.pixel_rgb565 !== want.pixel_rgb565)
                  report_mismatch("pixel_rgb565", 32'(rsp_payload.pixel_rgb565),
                                  32'(want.pixel_rgb565));
               if (rsp_payload.coverage !== want.coverage)
                  report_mismatch("coverage", 32'(rsp_payload.coverage), 32'(want.coverage));
            end
         end
         if (req_valid && req_ready) begin
            expected_pixels.push_back(filter_quad(req_payload));
            taken_count++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      logic [15:0] word [4];
      int kind;
      int pick;

      // directed corners
      push_quad(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_quad(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      push_quad(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      push_quad(16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF); // transparent but colored
      push_quad(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      push_quad(16'h0000, 16'h0000, 16'h0000, 16'h1FFF);
      push_quad(16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF);
      push_quad(16'hFC00, 16'hFC00, 16'hFC00, 16'hFC00);
      push_quad(16'h83E0, 16'h83E0, 16'h83E0, 16'h83E0);
      push_quad(16'h801F, 16'h801F, 16'h801F, 16'h801F);
      push_quad(16'h7F00, 16'h70F0, 16'h700F, 16'h7FFF);
      push_quad(16'h4FFF, 16'h4FFF, 16'h4FFF, 16'h4FFF);
      push_quad(16'h1000, 16'h2FFF, 16'h3A5A, 16'h6123);
      push_quad(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      push_quad(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      push_quad(16'h8421, 16'h7BDE, 16'h0F0F, 16'hF0F0);
      push_quad(16'hFFFF, 16'h7FFF, 16'h0FFF, 16'h8000);
      push_quad(16'h1FFF, 16'h1000, 16'h1F00, 16'h100F);
      push_quad(16'h7000, 16'h7000, 16'h0FFF, 16'h0FFF);

      for (int n = 0; n < RANDOM_QUADS; n++) begin
         kind = $urandom_range(0, 9);
         pick = $urandom_range(0, 3);
         for (int k = 0; k < 4; k++) begin
            word[k] = 16'($urandom);
            case (kind)
               3, 4: begin
                  word[k][15] = 1'b1;
               end
               5, 6: begin
                  word[k][15] = 1'b0;
               end
               7: begin
                  if ($urandom_range(0, 1) == 0) word[k][15:12] = 4'h0;
               end
               8: begin
                  word[k][15:12] = 4'h0;
               end
               9: begin
                  if (k == pick) word[k][15] = 1'b1;
                  else word[k][15:12] = 4'h0;
               end
               default: begin
               end
            endcase
         end
         push_quad(word[0], word[1], word[2], word[3]);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(pending_quads.size() == 0 && !req_valid && expected_pixels.size() == 0)
             && quiet_cycles < QUIET_LIMIT)
         @(posedge clock);

      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_rgb5a3_premultiplied_2x2_downsample_unit NOT OK");
         $finish;
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (expected_pixels.size() != 0)
            report_mismatch("missing beats", 32'(expected_pixels.size()), 0);
         if (mismatch_count == 0)
            $display("tb_rgb5a3_premultiplied_2x2_downsample_unit OK");
         else
            $display("tb_rgb5a3_premultiplied_2x2_downsample_unit NOT OK");
         $finish;
      end
   end

endmodule
